[design/dqke_pkg.sv]
// Shared types and constants for the DNS query key extractor.
// Used by dqke_parser, dqke_out_reg and dns_query_key_extractor_top.
package dqke_pkg;

  localparam int MAX_KEY_LEN_DEF = 255;
  localparam int MAX_LABELS_DEF  = 128;

  localparam logic [15:0] SERVICE_PORT_RST = 16'd53;

  // Frame byte positions, counted from the Ethernet destination address.
  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_SMAC_END  = 6'd6;
  localparam logic [POS_W-1:0] POS_CMAC_END  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_IHL       = 6'd14;
  localparam logic [POS_W-1:0] POS_PROTO     = 6'd23;
  localparam logic [POS_W-1:0] POS_IP_START  = 6'd26;
  localparam logic [POS_W-1:0] POS_IP_END    = 6'd34;
  localparam logic [POS_W-1:0] POS_SPORT_HI  = 6'd34;
  localparam logic [POS_W-1:0] POS_SPORT_LO  = 6'd35;
  localparam logic [POS_W-1:0] POS_DPORT_HI  = 6'd36;
  localparam logic [POS_W-1:0] POS_DPORT_LO  = 6'd37;
  localparam logic [POS_W-1:0] POS_ID_HI     = 6'd42;
  localparam logic [POS_W-1:0] POS_ID_LO     = 6'd43;
  localparam logic [POS_W-1:0] POS_FLAGS     = 6'd44;
  localparam logic [POS_W-1:0] POS_QDCNT_HI  = 6'd48;
  localparam logic [POS_W-1:0] POS_QDCNT_LO  = 6'd49;
  localparam logic [POS_W-1:0] POS_QNAME     = 6'd54;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [3:0] IHL_NO_OPT    = 4'd5;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] QR_MASK       = 8'h80;
  localparam logic [7:0] QDCOUNT_HI    = 8'd0;
  localparam logic [7:0] QDCOUNT_LO    = 8'd1;
  localparam logic [7:0] LABEL_MAX     = 8'd63;
  localparam logic [7:0] CASE_BIT      = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] ROOT_LABEL    = 8'h00;

  localparam logic KIND_KEY     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic VERDICT_QUERY = 1'b0;
  localparam logic VERDICT_PASS  = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  key_byte;
    logic [7:0]  key_index;
    logic        verdict;
    logic [15:0] query_type;
    logic [7:0]  key_length;
    logic [15:0] transaction_id;
    logic [15:0] client_port;
    logic [31:0] client_ip;
    logic [31:0] server_ip;
    logic [47:0] client_mac;
    logic [47:0] server_mac;
  } dqke_res_t;

endpackage

[design/dqke_parser.sv]
// Per-frame parse state: header checks, field capture and query name walk.
// Produces at most one result per accepted byte. Depends on dqke_pkg.
module dqke_parser import dqke_pkg::*; #(
  parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
  parameter int MAX_LABELS  = MAX_LABELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  pkt_byte,
  input  logic        frame_end,
  input  logic [15:0] service_port,
  output logic        res_valid,
  output dqke_res_t   res
);

  localparam int LBL_W = $clog2(MAX_LABELS + 1);

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_LABEL, PH_TAIL, PH_DONE, PH_IDLE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [5:0]         lbl_rem_r, lbl_rem_nxt;
  logic [7:0]         offset_r, offset_nxt;
  logic [LBL_W-1:0]   lbl_cnt_r, lbl_cnt_nxt;
  logic               reject_r, reject_nxt;
  logic [2:0]         tail_r, tail_nxt;
  logic [47:0]        smac_r, smac_nxt;
  logic [47:0]        cmac_r, cmac_nxt;
  logic [63:0]        ip_r, ip_nxt;
  logic [15:0]        cport_r, cport_nxt;
  logic [15:0]        txid_r, txid_nxt;
  logic [15:0]        qtype_r, qtype_nxt;

  logic               emit;
  logic [7:0]         kb;
  logic [7:0]         ki;
  logic [8:0]         len_sum;

  assign len_sum = {1'b0, offset_r} + 9'd1 + {3'b000, pkt_byte[5:0]};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    lbl_rem_nxt = lbl_rem_r;
    offset_nxt  = offset_r;
    lbl_cnt_nxt = lbl_cnt_r;
    reject_nxt  = reject_r;
    tail_nxt    = tail_r;
    smac_nxt    = smac_r;
    cmac_nxt    = cmac_r;
    ip_nxt      = ip_r;
    cport_nxt   = cport_r;
    txid_nxt    = txid_r;
    qtype_nxt   = qtype_r;
    emit        = 1'b0;
    kb          = 8'd0;
    ki          = 8'd0;

    case (phase_r)
      PH_HDR: begin
        if (pos_r < POS_SMAC_END) begin
          smac_nxt = {smac_r[39:0], pkt_byte};
        end else if (pos_r < POS_CMAC_END) begin
          cmac_nxt = {cmac_r[39:0], pkt_byte};
        end else if (pos_r == POS_ETYPE_HI) begin
          if (pkt_byte != ETYPE_IPV4_HI) reject_nxt = 1'b1;
        end else if (pos_r == POS_ETYPE_LO) begin
          if (pkt_byte != ETYPE_IPV4_LO) reject_nxt = 1'b1;
        end else if (pos_r == POS_IHL) begin
          if (pkt_byte[3:0] != IHL_NO_OPT) reject_nxt = 1'b1;
        end else if (pos_r == POS_PROTO) begin
          if (pkt_byte != PROTO_UDP) reject_nxt = 1'b1;
        end else if (pos_r >= POS_IP_START && pos_r < POS_IP_END) begin
          ip_nxt = {ip_r[55:0], pkt_byte};
        end else if (pos_r == POS_SPORT_HI || pos_r == POS_SPORT_LO) begin
          cport_nxt = {cport_r[7:0], pkt_byte};
        end else if (pos_r == POS_DPORT_HI) begin
          if (pkt_byte != service_port[15:8]) reject_nxt = 1'b1;
        end else if (pos_r == POS_DPORT_LO) begin
          if (pkt_byte != service_port[7:0]) reject_nxt = 1'b1;
        end else if (pos_r == POS_ID_HI || pos_r == POS_ID_LO) begin
          txid_nxt = {txid_r[7:0], pkt_byte};
        end else if (pos_r == POS_FLAGS) begin
          if ((pkt_byte & QR_MASK) != 8'd0) reject_nxt = 1'b1;
        end else if (pos_r == POS_QDCNT_HI) begin
          if (pkt_byte != QDCOUNT_HI) reject_nxt = 1'b1;
        end else if (pos_r == POS_QDCNT_LO) begin
          if (pkt_byte != QDCOUNT_LO) reject_nxt = 1'b1;
        end
        // a header reject keeps the phase; the name walk simply never starts
        if (pos_r == POS_QNAME - 6'd1 && !reject_nxt) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (lbl_cnt_r >= LBL_W'(MAX_LABELS)) begin
          reject_nxt = 1'b1;
          phase_nxt  = PH_IDLE;
        end else if (pkt_byte == ROOT_LABEL) begin
          if (offset_r >= 8'(MAX_KEY_LEN)) begin
            reject_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            emit       = 1'b1;
            kb         = ROOT_LABEL;
            ki         = offset_r;
            offset_nxt = offset_r + 8'd1;
            phase_nxt  = PH_TAIL;
          end
        end else if (pkt_byte > LABEL_MAX || len_sum > 9'(MAX_KEY_LEN)) begin
          // also catches compression pointers
          reject_nxt = 1'b1;
          phase_nxt  = PH_IDLE;
        end else begin
          emit        = 1'b1;
          kb          = pkt_byte;
          ki          = offset_r;
          offset_nxt  = offset_r + 8'd1;
          lbl_rem_nxt = pkt_byte[5:0];
          lbl_cnt_nxt = lbl_cnt_r + LBL_W'(1);
          phase_nxt   = PH_LABEL;
        end
      end
      PH_LABEL: begin
        emit = 1'b1;
        kb   = pkt_byte;
        if (pkt_byte >= CHAR_UPPER_A && pkt_byte <= CHAR_UPPER_Z) kb = pkt_byte + CASE_BIT;
        ki          = offset_r;
        offset_nxt  = offset_r + 8'd1;
        lbl_rem_nxt = lbl_rem_r - 6'd1;
        if (lbl_rem_nxt == 6'd0) phase_nxt = PH_LEN;
      end
      PH_TAIL: begin
        if (tail_r < 3'd2) qtype_nxt = {qtype_r[7:0], pkt_byte};
        tail_nxt = tail_r + 3'd1;
        if (tail_nxt >= 3'd4) phase_nxt = PH_DONE;
      end
      PH_DONE, PH_IDLE: begin
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (pos_r != POS_QNAME) pos_nxt = pos_r + 6'd1;
  end

  // result for this byte, built from the updated capture state
  always_comb begin
    res       = '0;
    res_valid = frame_end || emit;
    if (frame_end) begin
      res.result_kind    = KIND_VERDICT;
      res.verdict        = (!reject_nxt && phase_nxt == PH_DONE) ? VERDICT_QUERY
                                                                 : VERDICT_PASS;
      res.query_type     = qtype_nxt;
      res.key_length     = offset_nxt;
      res.transaction_id = txid_nxt;
      res.client_port    = cport_nxt;
      res.client_ip      = ip_nxt[63:32];
      res.server_ip      = ip_nxt[31:0];
      res.client_mac     = cmac_nxt;
      res.server_mac     = smac_nxt;
    end else begin
      res.result_kind = KIND_KEY;
      res.key_byte    = kb;
      res.key_index   = ki;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && frame_end)) begin
      phase_r   <= PH_HDR;
      pos_r     <= '0;
      lbl_rem_r <= '0;
      offset_r  <= '0;
      lbl_cnt_r <= '0;
      reject_r  <= 1'b0;
      tail_r    <= '0;
      smac_r    <= '0;
      cmac_r    <= '0;
      ip_r      <= '0;
      cport_r   <= '0;
      txid_r    <= '0;
      qtype_r   <= '0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      lbl_rem_r <= lbl_rem_nxt;
      offset_r  <= offset_nxt;
      lbl_cnt_r <= lbl_cnt_nxt;
      reject_r  <= reject_nxt;
      tail_r    <= tail_nxt;
      smac_r    <= smac_nxt;
      cmac_r    <= cmac_nxt;
      ip_r      <= ip_nxt;
      cport_r   <= cport_nxt;
      txid_r    <= txid_nxt;
      qtype_r   <= qtype_nxt;
    end
  end

endmodule

[design/dqke_out_reg.sv]
// Result register between the parser and the result channel.
// Depends on dqke_pkg for the result record type.
module dqke_out_reg import dqke_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  dqke_res_t res_in,
  input  logic      out_ready,
  output logic      can_load,
  output logic      out_valid,
  output dqke_res_t res_out
);

  logic      valid_r, valid_nxt;
  dqke_res_t res_r;

  // free when empty or when the held result leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

[design/dns_query_key_extractor_top.sv]
// Top level of the DNS query key extractor.
// Instantiates dqke_parser and dqke_out_reg; depends on dqke_pkg.

// Takes an Ethernet frame one byte per transfer and, for an IPv4/UDP DNS query
// to cfg_service_port (reset 53), emits every byte of the lowercased wire-format
// query name with its index, then one verdict record on the frame's last byte
// (verdict 0: valid query, 1: pass to stack) carrying qtype, key length,
// transaction ID, client port, addresses and MACs. Each byte is parsed in the
// cycle it is accepted and its result sits in the result register the next
// cycle. A byte is accepted in every cycle unless the result register holds a
// result the consumer has not taken, so in_ready is high while that register
// is empty or out_ready is high. The configuration register is always ready
// and must only be written between frames.
module dns_query_key_extractor_top import dqke_pkg::*; #(
  parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
  parameter int MAX_LABELS  = MAX_LABELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_service_port,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_key_byte,
  output logic [7:0]  out_key_index,
  output logic        out_verdict,
  output logic [15:0] out_query_type,
  output logic [7:0]  out_key_length,
  output logic [15:0] out_transaction_id,
  output logic [15:0] out_client_port,
  output logic [31:0] out_client_ip,
  output logic [31:0] out_server_ip,
  output logic [47:0] out_client_mac,
  output logic [47:0] out_server_mac
);

  logic [15:0] service_port_r;
  logic        in_acc;
  logic        res_valid;
  logic        can_load;
  dqke_res_t   res;
  dqke_res_t   res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_port_r <= SERVICE_PORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      service_port_r <= cfg_service_port;
    end
  end

  assign in_ready = can_load;
  assign in_acc   = in_valid && in_ready;

  dqke_parser #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .MAX_LABELS  (MAX_LABELS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .pkt_byte     (in_pkt_byte),
    .frame_end    (in_frame_end),
    .service_port (service_port_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  dqke_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_result_kind    = res_out.result_kind;
  assign out_key_byte       = res_out.key_byte;
  assign out_key_index      = res_out.key_index;
  assign out_verdict        = res_out.verdict;
  assign out_query_type     = res_out.query_type;
  assign out_key_length     = res_out.key_length;
  assign out_transaction_id = res_out.transaction_id;
  assign out_client_port    = res_out.client_port;
  assign out_client_ip      = res_out.client_ip;
  assign out_server_ip      = res_out.server_ip;
  assign out_client_mac     = res_out.client_mac;
  assign out_server_mac     = res_out.server_mac;

  // the last byte of a frame always yields a verdict record next cycle
  a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_end |=> out_valid && out_result_kind == KIND_VERDICT)
    else $error("frame end without verdict record");

  a_key_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_KEY |->
      out_verdict == 1'b0 && out_key_length == 8'd0 && out_query_type == 16'd0 &&
      out_client_ip == 32'd0 && out_server_mac == 48'd0)
    else $error("key result carries record fields");

  a_verdict_key_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_VERDICT |->
      out_key_byte == 8'd0 && out_key_index == 8'd0)
    else $error("verdict record carries key byte");

  // an accepted query has at least the root byte in its key
  a_query_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_VERDICT && out_verdict == VERDICT_QUERY |->
      out_key_length != 8'd0)
    else $error("valid query with empty key");

endmodule

[bench/tb_dns_query_key_extractor_top.sv]
// Testbench for dns_query_key_extractor_top: directed and random Ethernet frames,
// every key byte and verdict record checked against an in-bench frame parser.
// Depends on dqke_pkg and the RTL top level.
module tb_dns_query_key_extractor_top import dqke_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 40;
  localparam int NOT_TYPED    = -1;
  localparam int NUM_ROWS     = 25;

  localparam logic [7:0] NO_PATCH  = 8'hFF;
  localparam logic [7:0] FULL_LEN  = 8'd0;
  localparam logic [1:0] EXP_QUERY = {1'b0, VERDICT_QUERY};
  localparam logic [1:0] EXP_PASS  = {1'b0, VERDICT_PASS};
  localparam logic [1:0] EXP_NONE  = 2'b10;

  typedef enum logic [2:0] {
    SCAN_HDR, SCAN_LEN, SCAN_LABEL, SCAN_TAIL, SCAN_DONE, SCAN_SKIP
  } scan_phase_e;

  typedef enum logic [3:0] {
    NAME_RANDOM, NAME_MIXED_CASE, NAME_ROOT_ONLY, NAME_MAX_LABEL, NAME_FULL_KEY,
    NAME_ROOT_PAST_MAX, NAME_TOO_LONG, NAME_LABEL_64, NAME_POINTER, NAME_MANY_LABELS
  } name_shape_e;

  typedef struct packed {
    name_shape_e shape;
    logic [7:0]  patch_pos;
    logic [7:0]  patch_val;
    logic [7:0]  keep_len;
    logic [7:0]  trailer;
    logic [1:0]  verdict_exp;
  } frame_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_service_port;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_pkt_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [7:0]  out_key_byte;
  logic [7:0]  out_key_index;
  logic        out_verdict;
  logic [15:0] out_query_type;
  logic [7:0]  out_key_length;
  logic [15:0] out_transaction_id;
  logic [15:0] out_client_port;
  logic [31:0] out_client_ip;
  logic [31:0] out_server_ip;
  logic [47:0] out_client_mac;
  logic [47:0] out_server_mac;

  dns_query_key_extractor_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_service_port   (cfg_service_port),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pkt_byte        (in_pkt_byte),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_key_byte       (out_key_byte),
    .out_key_index      (out_key_index),
    .out_verdict        (out_verdict),
    .out_query_type     (out_query_type),
    .out_key_length     (out_key_length),
    .out_transaction_id (out_transaction_id),
    .out_client_port    (out_client_port),
    .out_client_ip      (out_client_ip),
    .out_server_ip      (out_server_ip),
    .out_client_mac     (out_client_mac),
    .out_server_mac     (out_server_mac)
  );

  // Parser model state
  logic [15:0] svc_port;
  int          byte_pos;
  scan_phase_e scan;
  int          label_left;
  int          key_off;
  int          labels_seen;
  bit          rejected;
  int          tail_seen;
  logic [47:0] server_mac_acc;
  logic [47:0] client_mac_acc;
  logic [63:0] ip_pair_acc;
  logic [15:0] client_port_acc;
  logic [15:0] txn_id_acc;
  logic [15:0] qtype_acc;

  dqke_res_t   key_and_verdict_q[$];
  dqke_res_t   oldest_exp;
  logic [7:0]  frame_bytes[$];
  int          verdict_override;
  int          random_items;
  int          mismatches;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_requests;
  int          hold_served;
  int          hold_left;

  frame_row_t directed_rows [NUM_ROWS] = '{
    '{NAME_MIXED_CASE,    NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_QUERY},
    '{NAME_ROOT_ONLY,     NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_QUERY},
    '{NAME_MAX_LABEL,     NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_QUERY},
    '{NAME_FULL_KEY,      NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_QUERY},
    '{NAME_ROOT_PAST_MAX, NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_TOO_LONG,      NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_LABEL_64,      NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_POINTER,       NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_MANY_LABELS,   NO_PATCH,         8'h00, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_ETYPE_HI), 8'h86, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_ETYPE_LO), 8'hDD, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_IHL),      8'h46, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_PROTO),    8'h06, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_DPORT_HI), 8'h01, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_DPORT_LO), 8'h36, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_FLAGS),    8'h80, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_QDCNT_HI), 8'h01, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_QDCNT_LO), 8'h02, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        8'(POS_QDCNT_LO), 8'h00, FULL_LEN, 8'd0, EXP_PASS},
    '{NAME_RANDOM,        NO_PATCH,         8'h00, 8'd1,     8'd0, EXP_PASS},
    '{NAME_RANDOM,        NO_PATCH,         8'h00, 8'd40,    8'd0, EXP_PASS},
    '{NAME_MIXED_CASE,    NO_PATCH,         8'h00, 8'd57,    8'd0, EXP_PASS},
    '{NAME_MIXED_CASE,    NO_PATCH,         8'h00, 8'd74,    8'd0, EXP_PASS},
    '{NAME_RANDOM,        NO_PATCH,         8'h00, FULL_LEN, 8'd6, EXP_NONE},
    '{NAME_MIXED_CASE,    8'(POS_IHL),      8'hF5, FULL_LEN, 8'd1, EXP_QUERY}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic void clear_frame_state();
    byte_pos        = 0;
    scan            = SCAN_HDR;
    label_left      = 0;
    key_off         = 0;
    labels_seen     = 0;
    rejected        = 1'b0;
    tail_seen       = 0;
    server_mac_acc  = '0;
    client_mac_acc  = '0;
    ip_pair_acc     = '0;
    client_port_acc = '0;
    txn_id_acc      = '0;
    qtype_acc       = '0;
  endfunction

  function automatic void flag_reject();
    rejected = 1'b1;
    if (scan != SCAN_HDR)
      scan = SCAN_SKIP;
  endfunction

  // Advance the parser model by one transfer and queue the result it causes.
  function automatic void parse_frame_byte(logic [7:0] b, logic last);
    dqke_res_t  r;
    bit         emit;
    logic [7:0] kb;
    int         ki;
    emit = 1'b0;
    kb   = '0;
    ki   = 0;
    if (scan == SCAN_HDR) begin
      if (byte_pos < POS_SMAC_END) server_mac_acc = {server_mac_acc[39:0], b};
      else if (byte_pos < POS_CMAC_END) client_mac_acc = {client_mac_acc[39:0], b};
      else if (byte_pos == POS_ETYPE_HI) begin
        if (b != ETYPE_IPV4_HI) flag_reject();
      end else if (byte_pos == POS_ETYPE_LO) begin
        if (b != ETYPE_IPV4_LO) flag_reject();
      end else if (byte_pos == POS_IHL) begin
        if (b[3:0] != IHL_NO_OPT) flag_reject();
      end else if (byte_pos == POS_PROTO) begin
        if (b != PROTO_UDP) flag_reject();
      end else if (byte_pos >= POS_IP_START && byte_pos < POS_IP_END)
        ip_pair_acc = {ip_pair_acc[55:0], b};
      else if (byte_pos == POS_SPORT_HI || byte_pos == POS_SPORT_LO)
        client_port_acc = {client_port_acc[7:0], b};
      else if (byte_pos == POS_DPORT_HI) begin
        if (b != svc_port[15:8]) flag_reject();
      end else if (byte_pos == POS_DPORT_LO) begin
        if (b != svc_port[7:0]) flag_reject();
      end else if (byte_pos == POS_ID_HI || byte_pos == POS_ID_LO)
        txn_id_acc = {txn_id_acc[7:0], b};
      else if (byte_pos == POS_FLAGS) begin
        if ((b & QR_MASK) != 8'd0) flag_reject();
      end else if (byte_pos == POS_QDCNT_HI) begin
        if (b != QDCOUNT_HI) flag_reject();
      end else if (byte_pos == POS_QDCNT_LO) begin
        if (b != QDCOUNT_LO) flag_reject();
      end
      if (byte_pos == POS_QNAME - 1 && !rejected)
        scan = SCAN_LEN;
    end else if (scan == SCAN_LEN) begin
      if (labels_seen >= MAX_LABELS_DEF) begin
        flag_reject();
      end else if (b == ROOT_LABEL) begin
        if (key_off >= MAX_KEY_LEN_DEF) begin
          flag_reject();
        end else begin
          emit = 1'b1;
          kb   = b;
          ki   = key_off;
          key_off++;
          scan = SCAN_TAIL;
        end
      end else if (b > LABEL_MAX || key_off + 1 + int'(b) > MAX_KEY_LEN_DEF) begin
        flag_reject();
      end else begin
        emit       = 1'b1;
        kb         = b;
        ki         = key_off;
        key_off++;
        label_left = int'(b);
        labels_seen++;
        scan       = SCAN_LABEL;
      end
    end else if (scan == SCAN_LABEL) begin
      kb = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_BIT : b;
      emit = 1'b1;
      ki   = key_off;
      key_off++;
      label_left--;
      if (label_left == 0)
        scan = SCAN_LEN;
    end else if (scan == SCAN_TAIL) begin
      if (tail_seen < 2)
        qtype_acc = {qtype_acc[7:0], b};
      tail_seen++;
      if (tail_seen >= 4)
        scan = SCAN_DONE;
    end
    if (byte_pos < 16'hFFFF)
      byte_pos++;

    r = '0;
    if (last) begin
      r.result_kind    = KIND_VERDICT;
      r.verdict        = (!rejected && scan == SCAN_DONE) ? VERDICT_QUERY : VERDICT_PASS;
      if (verdict_override != NOT_TYPED)
        r.verdict = verdict_override[0];
      r.query_type     = qtype_acc;
      r.key_length     = 8'(key_off);
      r.transaction_id = txn_id_acc;
      r.client_port    = client_port_acc;
      r.client_ip      = ip_pair_acc[63:32];
      r.server_ip      = ip_pair_acc[31:0];
      r.client_mac     = client_mac_acc;
      r.server_mac     = server_mac_acc;
      key_and_verdict_q.push_back(r);
      clear_frame_state();
    end else if (emit) begin
      r.result_kind = KIND_KEY;
      r.key_byte    = kb;
      r.key_index   = 8'(ki);
      key_and_verdict_q.push_back(r);
    end
  endfunction

  function automatic logic [7:0] name_char();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return CHAR_UPPER_A + 8'($urandom_range(0, 25));
    if (pick < 8) return 8'h61 + 8'($urandom_range(0, 25));
    // just outside the uppercase range
    if (pick == 8) return $urandom_range(0, 1) ? CHAR_UPPER_A - 8'd1 : CHAR_UPPER_Z + 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_label(int len);
    frame_bytes.push_back(8'(len));
    repeat (len) frame_bytes.push_back(name_char());
  endfunction

  function automatic void push_random(int count);
    repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Well-formed query to the current service port, name shaped as asked.
  function automatic void build_frame(name_shape_e shape, int trailer);
    string mixed;
    int    n;
    frame_bytes.delete();
    push_random(12);
    frame_bytes.push_back(ETYPE_IPV4_HI);
    frame_bytes.push_back(ETYPE_IPV4_LO);
    frame_bytes.push_back({4'($urandom_range(0, 15)), IHL_NO_OPT});
    push_random(8);
    frame_bytes.push_back(PROTO_UDP);
    push_random(12);
    frame_bytes.push_back(svc_port[15:8]);
    frame_bytes.push_back(svc_port[7:0]);
    push_random(6);
    frame_bytes.push_back(8'($urandom_range(0, 255)) & ~QR_MASK);
    push_random(3);
    frame_bytes.push_back(QDCOUNT_HI);
    frame_bytes.push_back(QDCOUNT_LO);
    push_random(4);
    case (shape)
      NAME_MIXED_CASE: begin
        mixed = "\003WwW\007ExAmPlE\003cOm";
        for (int k = 0; k < mixed.len(); k++)
          frame_bytes.push_back(mixed[k]);
      end
      NAME_MAX_LABEL: push_label(63);
      NAME_FULL_KEY: begin
        repeat (3) push_label(63);
        push_label(61);
      end
      NAME_ROOT_PAST_MAX: begin
        repeat (3) push_label(63);
        push_label(62);
      end
      NAME_TOO_LONG: repeat (4) push_label(63);
      NAME_LABEL_64: push_label(64);
      NAME_POINTER: begin
        push_label(3);
        frame_bytes.push_back(8'hC0);
        frame_bytes.push_back(8'h0C);
      end
      NAME_MANY_LABELS: repeat (130) push_label(1);
      NAME_RANDOM: begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 19) == 0)
            frame_bytes.push_back(8'($urandom_range(64, 255)));  // oversized or pointer
          else
            push_label((k == 0 && $urandom_range(0, 7) == 0) ? 63 : $urandom_range(1, 12));
        end
      end
      default: ;
    endcase
    frame_bytes.push_back(ROOT_LABEL);
    push_random(2);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h01);
    push_random(trailer);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
  endtask

  task automatic send_byte(logic [7:0] b, logic last, bit burst);
    if (!burst)
      while ($urandom_range(0, 99) < send_idle_pct) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_pkt_byte  <= b;
    in_frame_end <= last;
    do @(posedge clk); while (!in_ready);
    parse_frame_byte(b, last);
  endtask

  task automatic send_frame(int typed);
    bit burst;
    burst = ($urandom_range(0, 4) == 0);
    verdict_override = typed;
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, burst);
    verdict_override = NOT_TYPED;
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int          keep;
    logic [7:0]  check_pos [9];
    check_pos = '{8'(POS_ETYPE_HI), 8'(POS_ETYPE_LO), 8'(POS_IHL), 8'(POS_PROTO),
                  8'(POS_DPORT_HI), 8'(POS_DPORT_LO), 8'(POS_FLAGS), 8'(POS_QDCNT_HI),
                  8'(POS_QDCNT_LO)};
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      frame_bytes.delete();
      push_random($urandom_range(1, 80));
    end else begin
      if (pick < 12)
        build_frame(name_shape_e'($urandom_range(NAME_ROOT_ONLY, NAME_MANY_LABELS)), 0);
      else
        build_frame(NAME_RANDOM, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      if (pick >= 70 && pick < 78)
        frame_bytes[check_pos[$urandom_range(0, 8)]] ^= 8'($urandom_range(1, 255));
      else if (pick >= 78 && pick < 85)
        frame_bytes[$urandom_range(0, POS_QNAME - 1)] = 8'($urandom_range(0, 255));
      else if (pick >= 85 && pick < 95) begin
        keep = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
    end
    random_items += frame_bytes.size();
    send_frame(NOT_TYPED);
  endtask

  // Sender goes quiet until every expected result is out, then drains for DRAIN_CYCLES.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (key_and_verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_service_port(logic [15:0] port);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_service_port <= port;
    do @(posedge clk); while (!cfg_ready);
    svc_port = port;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side ready, with long hold-offs on request.
  initial begin
    out_ready   = 1'b0;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (key_and_verdict_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        oldest_exp = key_and_verdict_q.pop_front();
        cmp_field("result_kind", out_result_kind, oldest_exp.result_kind);
        cmp_field("key_byte", out_key_byte, oldest_exp.key_byte);
        cmp_field("key_index", out_key_index, oldest_exp.key_index);
        cmp_field("verdict", out_verdict, oldest_exp.verdict);
        cmp_field("query_type", out_query_type, oldest_exp.query_type);
        cmp_field("key_length", out_key_length, oldest_exp.key_length);
        cmp_field("transaction_id", out_transaction_id, oldest_exp.transaction_id);
        cmp_field("client_port", out_client_port, oldest_exp.client_port);
        cmp_field("client_ip", out_client_ip, oldest_exp.client_ip);
        cmp_field("server_ip", out_server_ip, oldest_exp.server_ip);
        cmp_field("client_mac", out_client_mac, oldest_exp.client_mac);
        cmp_field("server_mac", out_server_mac, oldest_exp.server_mac);
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_pkt_byte      = '0;
    in_frame_end     = 1'b0;
    cfg_valid        = 1'b0;
    cfg_service_port = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_requests    = 0;
    mismatches       = 0;
    random_items     = 0;
    verdict_override = NOT_TYPED;
    svc_port         = SERVICE_PORT_RST;
    clear_frame_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset service port
    for (int i = 0; i < NUM_ROWS; i++) begin
      build_frame(directed_rows[i].shape, directed_rows[i].trailer);
      if (directed_rows[i].patch_pos != NO_PATCH)
        frame_bytes[directed_rows[i].patch_pos] = directed_rows[i].patch_val;
      while (directed_rows[i].keep_len != FULL_LEN &&
             frame_bytes.size() > directed_rows[i].keep_len)
        void'(frame_bytes.pop_back());
      // stall the result side through the maximum-length key name so the input backs up
      if (directed_rows[i].shape == NAME_FULL_KEY)
        hold_requests++;
      send_frame(directed_rows[i].verdict_exp == EXP_NONE ? NOT_TYPED
                                                           : int'(directed_rows[i].verdict_exp));
    end

    // Random frames: one service port and one idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      wait_results_drained();
      case (ph)
        0: begin
          write_service_port(16'h0000);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_service_port(16'hFFFF);
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          write_service_port(16'($urandom_range(0, 65535)));
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          write_service_port(SERVICE_PORT_RST);
          send_idle_pct  = 36;
          recv_stall_pct = 36;
          hold_requests++;
        end
      endcase
      while (random_items < RANDOM_ITEMS * (ph + 1) / 4)
        send_random_frame();
    end

    wait_results_drained();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
design/dqke_pkg.sv
design/dqke_parser.sv
design/dqke_out_reg.sv
design/dns_query_key_extractor_top.sv
bench/tb_dns_query_key_extractor_top.sv
